// ===== rtl/core/mebs_pkg.sv =====
// Shared constants, types and helpers for the minimum-error boundary surface block.
package mebs_pkg;

    localparam int MAX_LINE      = 1024;
    localparam int LINE_AW       = $clog2(MAX_LINE);
    localparam int LEN_W         = LINE_AW + 1;
    localparam int COST_BITS     = 24;
    localparam int ERR_BITS      = 16;
    localparam int WIDTH_BITS    = 8;
    localparam int HEIGHT_BITS   = 11;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 11;

    typedef logic [COST_BITS-1:0] cost_t;
    typedef logic [LINE_AW-1:0]   pos_t;
    typedef logic [LEN_W-1:0]     len_t;
    typedef logic [ERR_BITS-1:0]  err_t;

    localparam cost_t COST_MAX = '1;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_BITS-1:0] CFG_SURFACE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SURFACE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DIRECTION      = 2'd2;

    // zero counts as one, anything above the line store depth as the depth
    function automatic len_t clamp_len(input logic [HEIGHT_BITS-1:0] v);
        logic [31:0] wide;
        wide = 32'(v);
        if (wide == 32'd0)
            return len_t'(1);
        else if (wide > 32'(MAX_LINE))
            return len_t'(MAX_LINE);
        else
            return len_t'(v);
    endfunction

endpackage

// ===== rtl/core/mebs_if.sv =====
// Channel interfaces: error samples in, cost results out, configuration writes.
interface mebs_in_if;
    import mebs_pkg::*;
    logic valid;
    logic ready;
    err_t error_value;
    modport source (output valid, output error_value, input ready);
    modport sink   (input valid, input error_value, output ready);
endinterface

interface mebs_out_if;
    import mebs_pkg::*;
    logic  valid;
    logic  ready;
    cost_t cumulative_cost;
    logic  line_end;
    pos_t  seam_position;
    logic  surface_end;
    modport source (output valid, output cumulative_cost, output line_end,
                    output seam_position, output surface_end, input ready);
    modport sink   (input valid, input cumulative_cost, input line_end,
                    input seam_position, input surface_end, output ready);
endinterface

interface mebs_cfg_if;
    import mebs_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/min_error_boundary_surface_core.sv =====
// Minimum-error boundary surface: streaming cumulative cost and per-line seam choice.
//
// Channels: "samples" carries one error value per transfer, in line order (rows
// when direction is 0, columns when it is 1). "results" carries one result per
// sample: the saturating cumulative cost, line_end and seam_position on the last
// value of a line, surface_end on the last value of the surface. "cfg" writes
// surface_width, surface_height and direction; it is always ready and must only
// be used while the block is idle.
// Each result is registered and offered the cycle after its sample; a sample is
// taken every cycle unless results stalls. Each transfer writes its cost into the
// line store and reads the next position and its right neighbor through the two
// read ports, so the store always holds the previous line ahead of the next sample.
// Reset clears position, line count and seam tracking and loads the register
// defaults; the line store is not cleared, the first line never reads it.
// When results stalls, the result register holds and samples drops ready; a
// new sample is taken in the same cycle the held result leaves.
module min_error_boundary_surface_core (
    input logic clk,
    input logic rst_n,
    mebs_cfg_if.sink   cfg,
    mebs_in_if.sink    samples,
    mebs_out_if.source results
);
    import mebs_pkg::*;

    logic [WIDTH_BITS-1:0]  width_reg;
    logic [HEIGHT_BITS-1:0] height_reg;
    logic                   dir_reg;

    pos_t  pos_reg;
    pos_t  line_reg;
    cost_t held_left_reg;
    cost_t best_cost_reg;
    pos_t  best_pos_reg;
    cost_t fwd_cost_reg;
    logic  here_fwd_reg;
    logic  right_fwd_reg;

    logic  out_valid_reg;
    cost_t cost_out_reg;
    logic  line_end_out_reg;
    pos_t  seam_out_reg;
    logic  surf_end_out_reg;

    logic                 accept;
    len_t                 len;
    len_t                 lines;
    cost_t                rd_here;
    cost_t                rd_right;
    cost_t                here_val;
    cost_t                right_val;
    len_t                 pos_inc;
    len_t                 line_inc;
    logic                 has_right;
    cost_t                best_nb;
    logic [COST_BITS:0]   sum;
    cost_t                cost;
    logic                 take_best;
    cost_t                new_best_cost;
    pos_t                 new_best_pos;
    logic                 line_end;
    logic                 surface_end;
    pos_t                 pos_next;
    pos_t                 right_addr;

    assign cfg.ready     = 1'b1;
    assign samples.ready = !out_valid_reg || results.ready;
    assign accept        = samples.valid && samples.ready;

    always_comb
    begin
        if (dir_reg)
        begin
            len   = clamp_len(height_reg);
            lines = clamp_len(HEIGHT_BITS'(width_reg));
        end
        else
        begin
            len   = clamp_len(HEIGHT_BITS'(width_reg));
            lines = clamp_len(height_reg);
        end
    end

    // a store entry written on the previous transfer is taken from the bypass
    assign here_val  = here_fwd_reg  ? fwd_cost_reg : rd_here;
    assign right_val = right_fwd_reg ? fwd_cost_reg : rd_right;

    assign pos_inc   = len_t'(pos_reg) + len_t'(1);
    assign line_inc  = len_t'(line_reg) + len_t'(1);
    assign has_right = pos_inc < len;

    always_comb
    begin
        best_nb = here_val;
        if (pos_reg != '0 && held_left_reg < best_nb)
        begin
            best_nb = held_left_reg;
        end
        if (has_right && right_val < best_nb)
        begin
            best_nb = right_val;
        end
    end

    assign sum  = (line_reg == '0)
                ? (COST_BITS+1)'(samples.error_value)
                : (COST_BITS+1)'(best_nb) + (COST_BITS+1)'(samples.error_value);
    assign cost = sum[COST_BITS] ? COST_MAX : sum[COST_BITS-1:0];

    assign take_best     = (pos_reg == '0) || (cost < best_cost_reg);
    assign new_best_cost = take_best ? cost : best_cost_reg;
    assign new_best_pos  = take_best ? pos_reg : best_pos_reg;

    assign line_end    = pos_inc >= len;
    assign surface_end = line_end && (line_inc >= lines);

    assign pos_next   = line_end ? '0 : pos_t'(pos_inc);
    assign right_addr = pos_next + pos_t'(1);

    mebs_ram #(
        .WIDTH (COST_BITS),
        .DEPTH (MAX_LINE)
    ) u_line_store (
        .clk     (clk),
        .we      (accept),
        .waddr   (pos_reg),
        .wdata   (cost),
        .re      (accept),
        .raddr_a (pos_next),
        .raddr_b (right_addr),
        .rdata_a (rd_here),
        .rdata_b (rd_right)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= WIDTH_BITS'(65);
            height_reg    <= HEIGHT_BITS'(20);
            dir_reg       <= 1'b0;
            pos_reg       <= '0;
            line_reg      <= '0;
            held_left_reg <= '0;
            best_cost_reg <= COST_MAX;
            best_pos_reg  <= '0;
            here_fwd_reg  <= 1'b0;
            right_fwd_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    CFG_SURFACE_WIDTH:  width_reg  <= cfg.data[WIDTH_BITS-1:0];
                    CFG_SURFACE_HEIGHT: height_reg <= cfg.data[HEIGHT_BITS-1:0];
                    CFG_DIRECTION:      dir_reg    <= cfg.data[0];
                    default:            ;
                endcase
            end

            if (accept)
            begin
                pos_reg       <= pos_next;
                here_fwd_reg  <= (pos_next == pos_reg);
                right_fwd_reg <= (right_addr == pos_reg);
                out_valid_reg <= 1'b1;
                if (line_end)
                begin
                    held_left_reg <= '0;
                    best_cost_reg <= COST_MAX;
                    best_pos_reg  <= '0;
                    line_reg      <= surface_end ? '0 : pos_t'(line_inc);
                end
                else
                begin
                    held_left_reg <= here_val;
                    best_cost_reg <= new_best_cost;
                    best_pos_reg  <= new_best_pos;
                end
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fwd_cost_reg     <= cost;
            cost_out_reg     <= cost;
            line_end_out_reg <= line_end;
            seam_out_reg     <= line_end ? new_best_pos : '0;
            surf_end_out_reg <= surface_end;
        end
    end

    assign results.valid           = out_valid_reg;
    assign results.cumulative_cost = cost_out_reg;
    assign results.line_end        = line_end_out_reg;
    assign results.seam_position   = seam_out_reg;
    assign results.surface_end     = surf_end_out_reg;

endmodule

// ===== rtl/core/mebs_ram.sv =====
// Generic RAM: one write port, two registered read ports.
module mebs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule
